### rtl/life_cellular_automaton_grid_top_defines.svh
// Assertion macros shared by the checker of the cell grid block.
// No dependencies; included by files that hold concurrent assertions.
`ifndef LIFE_CELLULAR_AUTOMATON_GRID_TOP_DEFINES_SVH
`define LIFE_CELLULAR_AUTOMATON_GRID_TOP_DEFINES_SVH

// Same-cycle implication, gated off during reset.
`define LCAG_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, gated off during reset.
`define LCAG_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/lcag_pkg.sv
// Package for the cell grid block: opcode type and rule constants.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps

package lcag_pkg;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_STEP  = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } opcode_type;

   localparam int unsigned CNT_W = 4;
   localparam int unsigned GEN_W = 32;

   localparam logic [CNT_W-1:0] BIRTH_COUNT = 4'd3;
   localparam logic [CNT_W-1:0] KEEP_LOW    = 4'd2;
   localparam logic [CNT_W-1:0] KEEP_HIGH   = 4'd3;

endpackage

### rtl/life_cellular_automaton_grid_top.sv
// Top level of the cell grid block: grid storage, generation step and handshake.
// Depends on lcag_pkg.
`timescale 1ns / 1ps

// Square grid of GRID_SIZE x GRID_SIZE cells held in flip-flops, each with a live
// bit and the neighbour count from the last step; borders do not wrap, so cells
// off the edge count as dead. Each request word carries an opcode and a cell
// address: write a cell, step one generation (all cells at once), read a cell,
// or clear the generation counter. Every request returns one response word with
// the addressed cell's state after the request, its stored count and the
// generation counter; an address off the grid reads as a dead cell with count
// zero and a write to it is dropped. Throughput is one word per clock while
// req_stall is low: a request is captured in an input register and executed
// against the grid once the output slot is free, where the whole step (eight-input
// count plus rule per cell) is combinational and the result lands in the output
// register. The input register can still take one word while a response waits
// under stall; req_stall rises only when both registers are full and rsp_stall is
// high. Reset clears the grid, all counts and the counter.
module life_cellular_automaton_grid_top
   import lcag_pkg::*;
#(
   parameter int GRID_SIZE = 16
) (
   input  logic                clock,
   input  logic                reset,
   // request words
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_opcode,
   input  logic [3:0]          req_row,
   input  logic [3:0]          req_col,
   input  logic                req_cell_value,
   // response words
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_cell_live,
   output logic [CNT_W-1:0]    rsp_neighbour_count,
   output logic [GEN_W-1:0]    rsp_generation
);

   localparam int IDX_W = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;

   // input register
   logic             s1_valid_ff, s1_valid_in;
   opcode_type       s1_opcode_ff;
   logic [3:0]       s1_row_ff, s1_col_ff;
   logic             s1_value_ff;

   // grid state
   logic [GRID_SIZE-1:0][GRID_SIZE-1:0]            cell_ff, cell_in;
   logic [GRID_SIZE-1:0][GRID_SIZE-1:0][CNT_W-1:0] count_ff, count_in;
   logic [GEN_W-1:0]                               gen_ff, gen_in;

   // zero ring around the grid for border cells
   logic [GRID_SIZE+1:0][GRID_SIZE+1:0] pad;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_live_ff, rsp_live_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [GEN_W-1:0] rsp_gen_ff;

   logic             out_free;
   logic             exec;
   logic             on_grid;
   logic [IDX_W-1:0] row_idx, col_idx;
   logic             do_write, do_step;

   // output slot frees when empty or being taken this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign exec      = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;

   assign on_grid = (32'(s1_row_ff) < GRID_SIZE) && (32'(s1_col_ff) < GRID_SIZE);
   assign row_idx = IDX_W'(s1_row_ff);
   assign col_idx = IDX_W'(s1_col_ff);

   assign do_write = exec && (s1_opcode_ff == OP_WRITE) && on_grid;
   assign do_step  = exec && (s1_opcode_ff == OP_STEP);

   genvar gi, gj;
   generate
      for (gi = 0; gi < GRID_SIZE + 2; gi++) begin : g_pad_r
         for (gj = 0; gj < GRID_SIZE + 2; gj++) begin : g_pad_c
            if (gi >= 1 && gi <= GRID_SIZE && gj >= 1 && gj <= GRID_SIZE) begin : g_in
               assign pad[gi][gj] = cell_ff[gi-1][gj-1];
            end else begin : g_edge
               assign pad[gi][gj] = 1'b0;
            end
         end
      end

      for (gi = 0; gi < GRID_SIZE; gi++) begin : g_row
         for (gj = 0; gj < GRID_SIZE; gj++) begin : g_col
            logic [CNT_W-1:0] nb_sum;
            logic             rule_live;
            logic             hit;

            // pad is offset by one: cell (gi,gj) sits at pad[gi+1][gj+1]
            assign nb_sum = CNT_W'(pad[gi][gj])     + CNT_W'(pad[gi][gj+1])
                          + CNT_W'(pad[gi][gj+2])   + CNT_W'(pad[gi+1][gj])
                          + CNT_W'(pad[gi+1][gj+2]) + CNT_W'(pad[gi+2][gj])
                          + CNT_W'(pad[gi+2][gj+1]) + CNT_W'(pad[gi+2][gj+2]);

            assign rule_live = cell_ff[gi][gj]
                             ? ((nb_sum == KEEP_LOW) || (nb_sum == KEEP_HIGH))
                             : (nb_sum == BIRTH_COUNT);

            assign hit = (row_idx == IDX_W'(gi)) && (col_idx == IDX_W'(gj));

            assign cell_in[gi][gj] = do_step              ? rule_live :
                                     (do_write && hit)    ? s1_value_ff :
                                                            cell_ff[gi][gj];
            assign count_in[gi][gj] = do_step ? nb_sum : count_ff[gi][gj];
         end
      end
   endgenerate

   // generation counter
   always_comb begin
      gen_in = gen_ff;
      if (exec) begin
         unique case (s1_opcode_ff)
            OP_STEP:  gen_in = gen_ff + GEN_W'(1);
            OP_CLEAR: gen_in = '0;
            default:  gen_in = gen_ff;
         endcase
      end
   end

   // response reflects the grid after this word
   assign rsp_live_in  = on_grid ? cell_in[row_idx][col_idx]  : 1'b0;
   assign rsp_count_in = on_grid ? count_in[row_idx][col_idx] : '0;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cell_ff      <= '0;
         count_ff     <= '0;
         gen_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cell_ff      <= cell_in;
         count_ff     <= count_in;
         gen_ff       <= gen_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_opcode_ff <= opcode_type'(req_opcode);
         s1_row_ff    <= req_row;
         s1_col_ff    <= req_col;
         s1_value_ff  <= req_cell_value;
      end
      if (exec) begin
         rsp_live_ff  <= rsp_live_in;
         rsp_count_ff <= rsp_count_in;
         rsp_gen_ff   <= gen_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cell_live       = rsp_live_ff;
   assign rsp_neighbour_count = rsp_count_ff;
   assign rsp_generation      = rsp_gen_ff;

endmodule

### rtl/lcag_checker.sv
// Port-level checker for the cell grid top level, with its bind statement.
// Depends on lcag_pkg and life_cellular_automaton_grid_top_defines.svh.
`timescale 1ns / 1ps
`include "life_cellular_automaton_grid_top_defines.svh"

module lcag_checker
   import lcag_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic             rsp_cell_live,
   input logic [CNT_W-1:0] rsp_neighbour_count,
   input logic [GEN_W-1:0] rsp_generation
);

   logic             seen_ff, seen_in;
   logic [GEN_W-1:0] last_gen_ff;
   logic             rsp_take;

   assign rsp_take = rsp_valid && !rsp_stall;

   always_comb begin
      seen_in = seen_ff || rsp_take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
      end
      if (rsp_take) begin
         last_gen_ff <= rsp_generation;
      end
   end

   // stalled response word holds
   `LCAG_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_cell_live) && $stable(rsp_neighbour_count) && $stable(rsp_generation), "stalled response word changed")

   // no response straight out of reset
   `LCAG_ASSERT_IMP(a_rst_empty, clock, 1'b0, $past(reset), !rsp_valid, "response valid right after reset")

   // at most eight neighbours
   `LCAG_ASSERT_IMP(a_cnt_range, clock, reset, rsp_valid, rsp_neighbour_count <= 4'd8, "neighbour count above eight")

   // one word between responses: counter holds, steps by one, or clears
   `LCAG_ASSERT_IMP(a_gen_step, clock, reset, rsp_valid && seen_ff, (rsp_generation == last_gen_ff) || (rsp_generation == last_gen_ff + GEN_W'(1)) || (rsp_generation == '0), "generation moved by more than one word")

endmodule

bind life_cellular_automaton_grid_top lcag_checker u_lcag_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_cell_live       (rsp_cell_live),
   .rsp_neighbour_count (rsp_neighbour_count),
   .rsp_generation      (rsp_generation)
);
